[rtl/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

   localparam int BYTE_CAP    = 8;
   localparam int MAX_FIND    = 8;
   localparam int MAX_REPL    = 8;
   localparam int PEND_DEPTH  = BYTE_CAP - 1;
   localparam int BYTE_W      = $clog2(BYTE_CAP);
   localparam int CNT_W       = $clog2(BYTE_CAP + 1);
   localparam int PEND_W      = $clog2(PEND_DEPTH + 1);
   localparam int LEN_W       = 4;
   localparam int PAT_W       = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] FIND_LIM =
      CNT_W'((MAX_FIND < BYTE_CAP) ? MAX_FIND : BYTE_CAP);
   localparam logic [CNT_W-1:0] REPL_LIM =
      CNT_W'((MAX_REPL < BYTE_CAP) ? MAX_REPL : BYTE_CAP);

   localparam logic [7:0] NEWLINE = 8'h0A;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_PATTERN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_LEN     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_PATTERN = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_LEN     = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [PAT_W-1:0] find_pattern;
      logic [LEN_W-1:0] find_len;
      logic [PAT_W-1:0] repl_pattern;
      logic [LEN_W-1:0] repl_len;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_CAP-1:0][7:0] bytes;
      logic [CNT_W-1:0]         count;
   } run_type;

   typedef struct packed {
      logic    valid;
      run_type run;
   } run_slot_type;

   function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                  input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CNT_W'(v) > lim) begin
         r = lim;
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/sfr_front.sv]
`default_nettype none

module sfr_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::PAT_W-1:0]        csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sfr_pkg::req_type                 req,
   input  wire logic                             q_full,
   output sfr_pkg::run_slot_type                 push
);

   localparam int NB = sfr_pkg::BYTE_CAP;

   sfr_pkg::cfg_type cfg_ff, cfg_in;

   logic [sfr_pkg::PEND_DEPTH-1:0][7:0] pend_ff, pend_in;
   logic [sfr_pkg::PEND_W-1:0]          count_ff, count_in;

   logic [sfr_pkg::CNT_W-1:0] flen, rlen, len1, kk;
   logic [NB-1:0][7:0]        buf_b, pat_b, repl_b;
   logic [NB-1:0][NB-1:0]     eq;
   logic [NB:0]               pm, ok;
   logic                      full_hit, release_all, accept;
   sfr_pkg::run_type          run;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sfr_pkg::CSR_FIND_PATTERN: cfg_in.find_pattern = csr_wdata;
            sfr_pkg::CSR_FIND_LEN:     cfg_in.find_len = csr_wdata[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_REPL_PATTERN: cfg_in.repl_pattern = csr_wdata;
            sfr_pkg::CSR_REPL_LEN:     cfg_in.repl_len = csr_wdata[sfr_pkg::LEN_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   assign flen = sfr_pkg::clamp_len(cfg_ff.find_len, sfr_pkg::FIND_LIM);
   assign rlen = sfr_pkg::clamp_len(cfg_ff.repl_len, sfr_pkg::REPL_LIM);
   assign len1 = sfr_pkg::CNT_W'(count_ff) + sfr_pkg::CNT_W'(1);
   assign release_all = req.flush || (req.in_byte == sfr_pkg::NEWLINE);

   // working buffer: pending bytes followed by the new byte
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         pat_b[i]  = cfg_ff.find_pattern[8*i +: 8];
         repl_b[i] = cfg_ff.repl_pattern[8*i +: 8];
         buf_b[i]  = req.in_byte;
      end
      for (int i = 0; i < sfr_pkg::PEND_DEPTH; i++) begin
         if (sfr_pkg::PEND_W'(i) < count_ff) begin
            buf_b[i] = pend_ff[i];
         end
      end
   end

   // eq[k][i]: byte k+i of the buffer equals search byte i
   always_comb begin
      for (int k = 0; k < NB; k++) begin
         for (int i = 0; i < NB; i++) begin
            eq[k][i] = 1'b0;
            if (k + i < NB) begin
               eq[k][i] = (buf_b[k+i] == pat_b[i]);
            end
         end
      end
   end

   // ok[k]: dropping the oldest k bytes leaves a proper prefix
   always_comb begin
      logic [sfr_pkg::CNT_W-1:0] rem;
      for (int k = 0; k <= NB; k++) begin
         rem   = len1 - sfr_pkg::CNT_W'(k);
         pm[k] = 1'b1;
         for (int i = 0; i < NB; i++) begin
            if (k < NB && sfr_pkg::CNT_W'(i) < rem) begin
               pm[k] = pm[k] & eq[k % NB][i];
            end
         end
         ok[k] = (sfr_pkg::CNT_W'(k) <= len1) &&
                 ((rem == '0) || ((rem < flen) && pm[k]));
      end
   end

   assign full_hit = (len1 == flen) && pm[0];

   always_comb begin
      kk = len1;
      for (int k = NB; k >= 0; k--) begin
         if (ok[k]) begin
            kk = sfr_pkg::CNT_W'(k);
         end
      end
   end

   always_comb begin
      logic [sfr_pkg::CNT_W-1:0] idx;
      run.bytes = buf_b;
      run.count = kk;
      count_in  = sfr_pkg::PEND_W'(len1 - kk);
      for (int j = 0; j < sfr_pkg::PEND_DEPTH; j++) begin
         idx        = kk + sfr_pkg::CNT_W'(j);
         pend_in[j] = buf_b[j];
         if (idx < sfr_pkg::CNT_W'(NB)) begin
            pend_in[j] = buf_b[idx[sfr_pkg::BYTE_W-1:0]];
         end
      end
      if (release_all) begin
         run.count = sfr_pkg::CNT_W'(count_ff) + sfr_pkg::CNT_W'(!req.flush);
         count_in  = '0;
      end else if (full_hit) begin
         run.bytes = repl_b;
         run.count = rlen;
         count_in  = '0;
      end
   end

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign push.valid = accept && (run.count != '0);
   assign push.run   = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.find_pattern <= '0;
         cfg_ff.find_len     <= sfr_pkg::LEN_W'(1);
         cfg_ff.repl_pattern <= '0;
         cfg_ff.repl_len     <= sfr_pkg::LEN_W'(1);
         count_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("run pushed into full queue");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && release_all) |=> (count_ff == '0))
      else $error("pending bytes left after newline or flush");

   a_pending_short: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((count_ff == '0) || (sfr_pkg::CNT_W'(count_ff) < $past(flen))))
      else $error("pending bytes not shorter than search string");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.run.count <= sfr_pkg::CNT_W'(NB)))
      else $error("run longer than byte capacity");
`endif

endmodule

`default_nettype wire

[rtl/sfr_queue.sv]
`default_nettype none

module sfr_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfr_pkg::run_slot_type push,
   input  wire logic                  pop,
   output logic                       full,
   output sfr_pkg::run_slot_type      head
);

   sfr_pkg::run_type mem_ff [sfr_pkg::QUEUE_DEPTH];

   logic [sfr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [sfr_pkg::QLVL_W-1:0] level_ff, level_in;
   logic                       do_push, do_pop;

   function automatic logic [sfr_pkg::QPTR_W-1:0] next_ptr(
      input logic [sfr_pkg::QPTR_W-1:0] p);
      logic [sfr_pkg::QPTR_W-1:0] r;
      if (p == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + sfr_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   assign full       = (level_ff == sfr_pkg::QLVL_W'(sfr_pkg::QUEUE_DEPTH));
   assign head.valid = (level_ff != '0);
   assign head.run   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + sfr_pkg::QLVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - sfr_pkg::QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.run;
      end
   end

endmodule

`default_nettype wire

[rtl/sfr_back.sv]
`default_nettype none

module sfr_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfr_pkg::run_slot_type head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sfr_pkg::rsp_type           rsp
);

   sfr_pkg::run_type            cur_ff, cur_in;
   logic                        busy_ff, busy_in;
   logic [sfr_pkg::BYTE_W-1:0]  idx_ff, idx_in;
   logic                        last, done, load;

   assign last = (sfr_pkg::CNT_W'(idx_ff) == (cur_ff.count - sfr_pkg::CNT_W'(1)));
   assign done = busy_ff && rsp_ready && last;
   assign load = head.valid && (!busy_ff || done);
   assign pop  = load;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         cur_in  = head.run;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         idx_in = idx_ff + sfr_pkg::BYTE_W'(1);
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp.out_byte    = cur_ff.bytes[idx_ff];
   assign rsp.last_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

[rtl/stream_find_replace_unit.sv]
// Streaming find-and-replace on a byte stream. Each request carries one text byte or a
// flush. Every leftmost, non-overlapping occurrence of the search string (csr index 0 bytes,
// index 1 length) is replaced by the replacement string (index 2 bytes, index 3 length);
// lengths of 0 act as 1 and lengths above 8 as 8. Bytes that may still start a match are
// held back; a newline or a flush releases them, and a newline itself passes unchanged.
// The front classifies one request per cycle while the run queue is not full, and writes its
// result bytes as one run into a two-entry run queue; the back sends one response byte per
// cycle while rsp_ready is high, marking the last byte of each run. Runs are at most 8 bytes;
// a request that yields no bytes writes no run. A run is registered in the queue and then in
// the back's current-run register. Write configuration only while idle.
`default_nettype none

module stream_find_replace_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfr_pkg::PAT_W-1:0]        csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sfr_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sfr_pkg::rsp_type                      rsp_data
);

   sfr_pkg::run_slot_type push, head;
   logic                  q_full, pop;

   sfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   sfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/tb_stream_find_replace_unit.sv]
`default_nettype none

module tb_stream_find_replace_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIND_CAP       = (sfr_pkg::MAX_FIND < sfr_pkg::BYTE_CAP) ?
                                   sfr_pkg::MAX_FIND : sfr_pkg::BYTE_CAP;
   localparam int REPL_CAP       = (sfr_pkg::MAX_REPL < sfr_pkg::BYTE_CAP) ?
                                   sfr_pkg::MAX_REPL : sfr_pkg::BYTE_CAP;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int SEGMENTS       = 8;
   localparam int ITEMS_PER_SEG  = 32;
   localparam int TIMEOUT_CYCLES = 250000;
   localparam int N_ROWS         = 36;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [sfr_pkg::CSR_INDEX_W-1:0] idx;
      logic [63:0]                     data;
      logic                            flush;
      logic                            typed;
      logic [3:0]                      n;
      logic [63:0]                     bytes;
   } stim_row_type;

   typedef struct packed {
      logic        typed;
      logic [3:0]  n;
      logic [63:0] bytes;
   } known_run_type;

   localparam stim_row_type DIRECTED_ROWS [0:N_ROWS-1] = '{
      '{ROW_REQ, '0, 64'h00, 1'b0, 1'b1, 4'd1, 64'h00},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd1, 64'hFF},
      '{ROW_REQ, '0, 64'h00, 1'b1, 1'b1, 4'd0, 64'h00},
      '{ROW_REQ, '0, 64'h0A, 1'b0, 1'b1, 4'd1, 64'h0A},
      '{ROW_CSR, sfr_pkg::CSR_FIND_PATTERN, 64'hFFFF_FFFF_FF63_6261, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_FIND_LEN,     64'h3,                   1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_REPL_PATTERN, 64'h5958,                1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_REPL_LEN,     64'h2,                   1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h61, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h62, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h63, 1'b0, 1'b1, 4'd2, 64'h5958},
      '{ROW_REQ, '0, 64'h61, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h62, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h0A, 1'b1, 1'b1, 4'd2, 64'h6261},
      '{ROW_REQ, '0, 64'h61, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h62, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_FIND_LEN,     64'hFFFF_FFFF_FFFF_FFF2, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h61, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h62, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_FIND_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_FIND_LEN,     64'hF,                   1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_REPL_PATTERN, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_REPL_LEN,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h0A, 1'b0, 1'b1, 4'd8, 64'h0AFF_FFFF_FFFF_FFFF},
      '{ROW_CSR, sfr_pkg::CSR_FIND_LEN,     64'h0,                   1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'hFF, 1'b0, 1'b1, 4'd8, 64'h0123_4567_89AB_CDEF},
      '{ROW_CSR, sfr_pkg::CSR_FIND_PATTERN, 64'h0A,                  1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_CSR, sfr_pkg::CSR_REPL_LEN,     64'h0,                   1'b0, 1'b0, 4'd0, 64'h0},
      '{ROW_REQ, '0, 64'h0A, 1'b0, 1'b1, 4'd1, 64'h0A}
   };

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sfr_pkg::PAT_W-1:0]       csr_wdata = '0;
   logic                            req_valid = 1'b0;
   sfr_pkg::req_type                req_data  = '0;
   logic                            rsp_ready = 1'b0;
   logic                            req_ready;
   logic                            rsp_valid;
   sfr_pkg::rsp_type                rsp_data;

   logic [sfr_pkg::PAT_W-1:0] find_reg     = '0;
   logic [sfr_pkg::LEN_W-1:0] find_len_reg = sfr_pkg::LEN_W'(1);
   logic [sfr_pkg::PAT_W-1:0] repl_reg     = '0;
   logic [sfr_pkg::LEN_W-1:0] repl_len_reg = sfr_pkg::LEN_W'(1);
   logic [7:0]                held_bytes [sfr_pkg::PEND_DEPTH];
   int                        held_count   = 0;

   sfr_pkg::rsp_type expected_text [$];
   known_run_type    known_runs [$];
   int               mismatches   = 0;
   int               gap_pct      = 0;
   int               stall_pct    = 0;
   int               hold_arm     = 0;
   int               hold_seen    = 0;
   int               hold_left    = 0;

   stream_find_replace_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int eff_len(input logic [sfr_pkg::LEN_W-1:0] v, input int cap);
      int r;
      r = int'(v);
      if (r < 1) r = 1;
      if (r > cap) r = cap;
      return r;
   endfunction

   function automatic bit is_search_prefix(input logic [7:0] w [sfr_pkg::BYTE_CAP+1],
                                           input int len);
      for (int i = 0; i < len; i++) begin
         if (w[i] != find_reg[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // one request of the rewrite; returns the number of output bytes
   function automatic int rewrite_step(input sfr_pkg::req_type r,
                                       output logic [7:0] outb [sfr_pkg::BYTE_CAP]);
      logic [7:0] work [sfr_pkg::BYTE_CAP+1];
      int         len;
      int         flen;
      int         rlen;
      int         n;
      len  = held_count;
      flen = eff_len(find_len_reg, FIND_CAP);
      rlen = eff_len(repl_len_reg, REPL_CAP);
      n    = 0;
      for (int i = 0; i < sfr_pkg::BYTE_CAP; i++) outb[i] = '0;
      for (int i = 0; i <= sfr_pkg::BYTE_CAP; i++) work[i] = '0;
      for (int i = 0; i < len; i++) work[i] = held_bytes[i];
      if (r.flush || r.in_byte == sfr_pkg::NEWLINE) begin
         for (int i = 0; i < len; i++) outb[n++] = work[i];
         if (!r.flush) outb[n++] = sfr_pkg::NEWLINE;
         len = 0;
      end else begin
         work[len++] = r.in_byte;
         if (len == flen && is_search_prefix(work, len)) begin
            for (int i = 0; i < rlen; i++) outb[n++] = repl_reg[8*i +: 8];
            len = 0;
         end else begin
            while (len > 0 && !(len < flen && is_search_prefix(work, len))) begin
               outb[n++] = work[0];
               for (int j = 0; j < len - 1; j++) work[j] = work[j+1];
               len--;
            end
         end
      end
      for (int i = 0; i < len; i++) held_bytes[i] = work[i];
      held_count = len;
      return n;
   endfunction

   always @(posedge clock) begin : scoreboard
      logic [7:0]       outb [sfr_pkg::BYTE_CAP];
      int               n;
      known_run_type    note;
      sfr_pkg::rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               sfr_pkg::CSR_FIND_PATTERN: find_reg     = csr_wdata;
               sfr_pkg::CSR_FIND_LEN:     find_len_reg = csr_wdata[sfr_pkg::LEN_W-1:0];
               sfr_pkg::CSR_REPL_PATTERN: repl_reg     = csr_wdata;
               sfr_pkg::CSR_REPL_LEN:     repl_len_reg = csr_wdata[sfr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            n    = rewrite_step(req_data, outb);
            note = known_runs.pop_front();
            if (note.typed) begin
               for (int i = 0; i < int'(note.n); i++) begin
                  want.out_byte    = note.bytes[8*i +: 8];
                  want.last_of_run = (i == int'(note.n) - 1);
                  expected_text.push_back(want);
               end
            end else begin
               for (int i = 0; i < n; i++) begin
                  want.out_byte    = outb[i];
                  want.last_of_run = (i == n - 1);
                  expected_text.push_back(want);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected response: out_byte %h last_of_run %b",
                      rsp_data.out_byte, rsp_data.last_of_run);
               mismatches++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run,
                         rsp_data.last_of_run);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_seen != hold_arm) begin
         hold_seen = hold_arm;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_req(input sfr_pkg::req_type r, input logic typed, input logic [3:0] n,
                           input logic [63:0] bytes);
      int gap;
      gap = 0;
      known_runs.push_back('{typed, n, bytes});
      while ($urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sfr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sfr_pkg::PAT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("[stream_find_replace_unit] ERROR");
      $finish;
   end

   initial begin
      sfr_pkg::req_type r;
      logic [7:0]       alpha [3];
      logic [63:0]      word;
      logic [63:0]      cur_find;
      logic [3:0]       lenv;
      int               flen_eff;
      int               count;
      int               pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[k]) begin
         if (DIRECTED_ROWS[k].kind == ROW_CSR) begin
            wait_idle();
            write_csr(DIRECTED_ROWS[k].idx, DIRECTED_ROWS[k].data);
         end else begin
            r.in_byte = DIRECTED_ROWS[k].data[7:0];
            r.flush   = DIRECTED_ROWS[k].flush;
            send_req(r, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].n, DIRECTED_ROWS[k].bytes);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(255));
         for (int i = 0; i < 8; i++) cur_find[8*i +: 8] = alpha[$urandom_range(2)];
         write_csr(sfr_pkg::CSR_FIND_PATTERN, cur_find);
         pick = $urandom_range(99);
         if (pick < 80) lenv = 4'($urandom_range(4, 1));
         else if (pick < 92) lenv = 4'($urandom_range(8, 5));
         else if (pick < 96) lenv = 4'd0;
         else lenv = 4'($urandom_range(15, 9));
         flen_eff = eff_len(lenv, FIND_CAP);
         word = {$urandom, $urandom};
         word[3:0] = lenv;
         write_csr(sfr_pkg::CSR_FIND_LEN, word);
         write_csr(sfr_pkg::CSR_REPL_PATTERN, {$urandom, $urandom});
         write_csr(sfr_pkg::CSR_REPL_LEN, {$urandom, $urandom});

         case (seg % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 82; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 82; end
            default: begin gap_pct = 19; stall_pct = 19; end
         endcase
         // receiver holds off while requests keep coming
         if (seg % 4 == 0) hold_arm++;

         count = 0;
         while (count < ITEMS_PER_SEG) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               for (int i = 0; i < flen_eff; i++) begin
                  r.in_byte = cur_find[8*i +: 8];
                  r.flush   = 1'b0;
                  send_req(r, 1'b0, 4'd0, 64'h0);
                  count++;
               end
            end else begin
               r.flush = 1'b0;
               if (pick < 65) begin
                  r.in_byte = alpha[$urandom_range(2)];
               end else if (pick < 80) begin
                  r.in_byte = 8'($urandom_range(255));
               end else if (pick < 88) begin
                  r.in_byte = sfr_pkg::NEWLINE;
               end else if (pick < 95) begin
                  r.flush   = 1'b1;
                  r.in_byte = $urandom_range(1) ? sfr_pkg::NEWLINE : 8'($urandom_range(255));
               end else begin
                  r.flush   = 1'($urandom_range(1));
                  r.in_byte = 8'($urandom_range(255));
               end
               send_req(r, 1'b0, 4'd0, 64'h0);
               count++;
            end
         end
      end

      gap_pct   = 0;
      stall_pct = 0;
      wait_idle();
      if (mismatches == 0 && expected_text.size() == 0) begin
         $display("[stream_find_replace_unit] OK");
      end else begin
         $display("[stream_find_replace_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace_unit.sv
tb/sv/tb_stream_find_replace_unit.sv
